### hdl/msbbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbbf_pkg
// shared types and constants of the msb-first bit-field access core
// ----------------------------------------------------------------------------
package msbbf_pkg;

   // operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // fixed field widths
   localparam int OFFSET_W = 12;
   localparam int COUNT_W  = 6;
   localparam int VALUE_W  = 32;

   localparam int BITS_PER_BYTE = 8;
   localparam logic [2:0] BIT_IN_BYTE_MASK = 3'h7;

   // byte step counter, a field spans at most five bytes
   localparam int STEP_W = 3;

   typedef struct packed {
      logic              load;
      logic              rd_en;
      logic              cap;
      logic              merge;
      logic              wr_en;
      logic              out_load;
      logic              clr_en;
      logic [STEP_W-1:0] step;
   } msbbf_cmd_type;

   typedef struct packed {
      logic              is_write;
      logic              skip;
      logic [STEP_W-1:0] nbytes;
      logic              clear_last;
   } msbbf_status_type;

endpackage : msbbf_pkg
`default_nettype wire

### hdl/msbbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbbf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module msbbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : msbbf_ram
`default_nettype wire

### hdl/msbbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbbf_ctrl
// sequencer: clearing pass, byte reads, merge, byte writes, result handoff
// ----------------------------------------------------------------------------
module msbbf_ctrl
   import msbbf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire msbbf_status_type status,
   output msbbf_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_DRAIN,
      ST_MERGE,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_step;

   assign last_step = (step_ff == (status.nbytes - STEP_W'(1)));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;
      // read data shows up in the cycle after the read is issued
      cmd.cap  = pend_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            step_in  = '0;
            state_in = status.skip ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = status.is_write ? ST_MERGE : ST_DONE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            step_in   = '0;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.wr_en = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   assign pend_in      = cmd.rd_en;
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending word");

   // every issued read is captured on the next cycle
   a_read_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> cmd.cap)
      else $error("read data not captured");

   // byte steps stay inside the span of the field
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en || cmd.wr_en) |-> (step_ff < status.nbytes))
      else $error("byte step beyond field span");

endmodule : msbbf_ctrl
`default_nettype wire

### hdl/msbbf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbbf_dpath
// request decode, byte window, merge and extract, byte store, result register
// ----------------------------------------------------------------------------
module msbbf_dpath
   import msbbf_pkg::*;
#(
   parameter int STORE_BYTES    = 512,
   parameter int MAX_FIELD_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire msbbf_cmd_type       cmd,
   output msbbf_status_type         status,
   input  wire logic                req_operation,
   input  wire logic [OFFSET_W-1:0] req_bit_offset,
   input  wire logic [COUNT_W-1:0]  req_bit_count,
   input  wire logic [VALUE_W-1:0]  req_write_value,
   output logic      [VALUE_W-1:0]  rsp_read_value,
   output logic                     rsp_range_error
);

   localparam int AW         = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int BYTE_IDX_W = OFFSET_W - 3;
   localparam int IW         = (AW > BYTE_IDX_W) ? AW : BYTE_IDX_W;
   localparam int STORE_BITS = STORE_BYTES * BITS_PER_BYTE;
   localparam int SB_W       = $clog2(STORE_BITS + 1);
   localparam int EW         = (SB_W > OFFSET_W + 1) ? SB_W : OFFSET_W + 1;
   localparam int MAX_BYTES  = (MAX_FIELD_BITS + 2 * (BITS_PER_BYTE - 1)) / BITS_PER_BYTE;
   localparam int WW         = MAX_BYTES * BITS_PER_BYTE;
   localparam int XW         = (WW > VALUE_W) ? WW : VALUE_W;

   // request decode
   logic [COUNT_W-1:0] cnt_sat;
   logic [2:0]         bit_in;
   logic [COUNT_W-1:0] span;
   logic [COUNT_W-1:0] span_up;
   logic [EW-1:0]      end_bit;
   logic               over;
   logic [VALUE_W-1:0] mask_calc;

   always_comb begin
      cnt_sat   = (req_bit_count > COUNT_W'(MAX_FIELD_BITS)) ?
                  COUNT_W'(MAX_FIELD_BITS) : req_bit_count;
      bit_in    = req_bit_offset[2:0] & BIT_IN_BYTE_MASK;
      span      = COUNT_W'(bit_in) + cnt_sat;
      span_up   = span + COUNT_W'(BITS_PER_BYTE - 1);
      end_bit   = EW'(req_bit_offset) + EW'(cnt_sat);
      over      = end_bit > EW'(STORE_BITS);
      mask_calc = ~({VALUE_W{1'b1}} << cnt_sat);
   end

   logic               op_ff;
   logic [IW-1:0]      first_ff;
   logic [STEP_W-1:0]  nbytes_ff;
   logic [2:0]         pad_ff;
   logic [VALUE_W-1:0] mask_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               err_ff;
   logic               skip_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         first_ff  <= IW'(req_bit_offset[OFFSET_W-1:3]);
         nbytes_ff <= STEP_W'(span_up >> 3);
         // bits left below the field in its last byte
         pad_ff    <= 3'(COUNT_W'(0) - span);
         mask_ff   <= mask_calc;
         value_ff  <= req_write_value & mask_calc;
         err_ff    <= (cnt_sat != '0) && over;
         skip_ff   <= (cnt_sat == '0) || over;
      end
   end

   // byte window, bytes enter at the low end in address order
   logic [WW-1:0]            window_ff;
   logic [BITS_PER_BYTE-1:0] rd_byte;
   logic [XW-1:0]            val_sh;
   logic [XW-1:0]            mask_sh;
   logic [WW-1:0]            merged;
   logic [XW-1:0]            win_sh;
   logic [VALUE_W-1:0]       field;

   always_comb begin
      val_sh  = XW'(value_ff) << pad_ff;
      mask_sh = XW'(mask_ff) << pad_ff;
      merged  = (window_ff & ~WW'(mask_sh)) | WW'(val_sh);
      win_sh  = XW'(window_ff) >> pad_ff;
      field   = win_sh[VALUE_W-1:0] & mask_ff;
   end

   always_ff @(posedge clock) begin
      priority if (cmd.cap) begin
         window_ff <= {window_ff[WW-BITS_PER_BYTE-1:0], rd_byte};
      end else if (cmd.merge) begin
         window_ff <= merged;
      end
   end

   // write back from the first byte, which sits highest in the window
   logic [STEP_W-1:0]        lane;
   logic [BITS_PER_BYTE-1:0] wr_byte;

   always_comb begin
      lane    = nbytes_ff - STEP_W'(1) - cmd.step;
      wr_byte = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         if (lane == STEP_W'(i)) begin
            wr_byte = window_ff[i*BITS_PER_BYTE +: BITS_PER_BYTE];
         end
      end
   end

   // clearing pass address
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   logic [IW-1:0]            acc_idx;
   logic [AW-1:0]            acc_addr;
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [BITS_PER_BYTE-1:0] ram_wdata;

   always_comb begin
      acc_idx   = first_ff + IW'(cmd.step);
      acc_addr  = acc_idx[AW-1:0];
      ram_we    = cmd.clr_en | cmd.wr_en;
      ram_waddr = cmd.clr_en ? clr_addr_ff : acc_addr;
      ram_wdata = cmd.clr_en ? '0 : wr_byte;
   end

   msbbf_ram #(
      .WIDTH (BITS_PER_BYTE),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (acc_addr),
      .rd_data (rd_byte)
   );

   // result register
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_err_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff <= ((op_ff == OP_READ) && !skip_ff) ? field : '0;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_read_value  = out_value_ff;
   assign rsp_range_error = out_err_ff;

   always_comb begin
      status            = '0;
      status.is_write   = (op_ff == OP_WRITE);
      status.skip       = skip_ff;
      status.nbytes     = nbytes_ff;
      status.clear_last = (clr_addr_ff == AW'(STORE_BYTES - 1));
   end

   // an access that is carried out spans one to MAX_BYTES bytes
   a_span_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (skip_ff || ((nbytes_ff != '0) && (nbytes_ff <= STEP_W'(MAX_BYTES)))))
      else $error("field span out of range");

   // store accesses never leave the store
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en || cmd.wr_en) |-> ({1'b0, acc_idx} < (IW + 1)'(STORE_BYTES)))
      else $error("byte access beyond store end");

endmodule : msbbf_dpath
`default_nettype wire

### hdl/msb_first_bit_field_access_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_field_access_core
// msb-first bit-field read and write over a byte store
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  operation, bit_offset,
//                                              bit_count, write_value
//   rsp      out        rsp_valid / rsp_ready  read_value, range_error
//
// one word at a time; every field byte passes the single byte-wide store port,
// reads fetch the field bytes, writes fetch, merge and write them back; zero count
// or out-of-range words skip the store
// after reset a clearing pass zeroes every byte, req_ready low
// a result waits in the output register while the next word is accepted;
// the following result holds until rsp_ready frees the register
// ----------------------------------------------------------------------------
module msb_first_bit_field_access_core
   import msbbf_pkg::*;
#(
   parameter int STORE_BYTES    = 512,
   parameter int MAX_FIELD_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_operation,
   input  wire logic [OFFSET_W-1:0] req_bit_offset,
   input  wire logic [COUNT_W-1:0]  req_bit_count,
   input  wire logic [VALUE_W-1:0]  req_write_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [VALUE_W-1:0]  rsp_read_value,
   output logic                     rsp_range_error
);

   msbbf_cmd_type    cmd;
   msbbf_status_type status;

   msbbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msbbf_dpath #(
      .STORE_BYTES    (STORE_BYTES),
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_bit_offset  (req_bit_offset),
      .req_bit_count   (req_bit_count),
      .req_write_value (req_write_value),
      .rsp_read_value  (rsp_read_value),
      .rsp_range_error (rsp_range_error)
   );

endmodule : msb_first_bit_field_access_core
`default_nettype wire

### dv/tb_msb_first_bit_field_access_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_field_access_core
// self-checking bench for the msb-first bit-field read/write core
//
// a directed set covers the store ends, zero counts, saturated counts and
// out-of-range fields, then about 1200 random words follow, mostly
// write/read-back pairs over a small dense region with full-range and
// near-end words mixed in. A bit-level shadow of the byte store predicts
// every result at request acceptance. Both channels idle in random bursts,
// and twice the response side holds off long enough to back up the core.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_field_access_core;
   import msbbf_pkg::*;

   localparam int STORE_BYTES    = 512;
   localparam int MAX_FIELD_BITS = 32;
   localparam int STORE_BITS     = STORE_BYTES * BITS_PER_BYTE;
   localparam int RANDOM_WORDS   = 1200;
   localparam int QUIET_TAIL     = 150;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 200000;

   typedef struct {
      logic                op;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  count;
      logic [VALUE_W-1:0]  value;
   } field_word_type;

   typedef struct {
      logic [VALUE_W-1:0] read_value;
      logic               range_error;
   } field_result_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic                req_operation   = OP_READ;
   logic [OFFSET_W-1:0] req_bit_offset  = '0;
   logic [COUNT_W-1:0]  req_bit_count   = '0;
   logic [VALUE_W-1:0]  req_write_value = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic                rsp_range_error;

   // shadow of the byte store, bit 7 of each byte is bit position 0
   logic [7:0]       shadow_store [STORE_BYTES];
   field_word_type   pending_words [$];
   field_result_type expected_fields [$];
   field_word_type   offered_word;

   int req_gap       = 0;
   int rsp_stall     = 0;
   int words_in      = 0;
   int hold_left     = 0;
   int holds_done    = 0;
   int mismatches    = 0;
   int cycle_count   = 0;
   int total_words   = 0;

   msb_first_bit_field_access_core #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_FIELD_BITS(MAX_FIELD_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_bit_offset (req_bit_offset),
      .req_bit_count  (req_bit_count),
      .req_write_value(req_write_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_range_error(rsp_range_error)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // applies one word to the shadow store and returns what the core must answer
   function automatic field_result_type access_field(input field_word_type w);
      field_result_type r;
      int               n;
      int               pos;
      r.read_value  = '0;
      r.range_error = 1'b0;
      n = (int'(w.count) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(w.count);
      if (n != 0) begin
         if (int'(w.offset) + n > STORE_BITS) begin
            r.range_error = 1'b1;
         end else if (w.op == OP_READ) begin
            for (int i = 0; i < n; i++) begin
               pos = int'(w.offset) + i;
               r.read_value = {r.read_value[VALUE_W-2:0],
                               shadow_store[pos / BITS_PER_BYTE][7 - (pos % BITS_PER_BYTE)]};
            end
         end else begin
            for (int i = 0; i < n; i++) begin
               pos = int'(w.offset) + i;
               shadow_store[pos / BITS_PER_BYTE][7 - (pos % BITS_PER_BYTE)] =
                  w.value[n - 1 - i];
            end
         end
      end
      return r;
   endfunction

   task automatic queue_word(input logic op, input int offset, input int count,
                             input logic [VALUE_W-1:0] value);
      field_word_type w;
      w.op     = op;
      w.offset = offset[OFFSET_W-1:0];
      w.count  = count[COUNT_W-1:0];
      w.value  = value;
      pending_words.push_back(w);
   endtask

   function automatic int pick_offset();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 511);
      else if (r < 8) return $urandom_range(0, STORE_BITS - 1);
      else return $urandom_range(STORE_BITS - 56, STORE_BITS - 1);
   endfunction

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      else if (r < 3) return $urandom_range(MAX_FIELD_BITS + 1, 63);
      else if (r < 6) return MAX_FIELD_BITS;
      else return $urandom_range(1, MAX_FIELD_BITS);
   endfunction

   // stimulus and end of run
   initial begin
      int                 off;
      int                 cnt;
      int                 r;
      logic [VALUE_W-1:0] val;

      for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = 8'h00;

      // directed part
      queue_word(OP_READ,  0,    32, 32'h0);
      queue_word(OP_WRITE, 0,    32, 32'hFFFF_FFFF);
      queue_word(OP_READ,  0,    32, 32'h0);
      queue_word(OP_READ,  4,    9,  32'hFFFF_FFFF);
      queue_word(OP_WRITE, 13,   17, 32'hDEA1_ABCD);
      queue_word(OP_READ,  8,    32, 32'h0);
      queue_word(OP_WRITE, 7,    1,  32'h0);
      queue_word(OP_READ,  7,    1,  32'h0);
      queue_word(OP_WRITE, 4093, 3,  32'h0000_0005);
      queue_word(OP_WRITE, 4095, 1,  32'h0000_0001);
      queue_word(OP_READ,  4064, 32, 32'h0);
      queue_word(OP_WRITE, 4095, 2,  32'hFFFF_FFFF);
      queue_word(OP_READ,  4090, 7,  32'h0);
      queue_word(OP_READ,  4095, 0,  32'h0);
      queue_word(OP_WRITE, 4095, 0,  32'hFFFF_FFFF);
      queue_word(OP_WRITE, 100,  63, 32'hA5A5_5A5A);
      queue_word(OP_READ,  100,  40, 32'h0);
      queue_word(OP_READ,  4070, 63, 32'h0);
      queue_word(OP_READ,  4064, 33, 32'h0);
      queue_word(OP_WRITE, 200,  5,  32'hFFFF_FFE0);
      queue_word(OP_READ,  198,  9,  32'h0);
      queue_word(OP_WRITE, 0,    32, 32'h0);
      queue_word(OP_READ,  0,    32, 32'h0);

      // random part: write/read-back pairs, single words, and noise
      while (pending_words.size() < RANDOM_WORDS + 23) begin
         r   = $urandom_range(0, 9);
         off = pick_offset();
         cnt = pick_count();
         val = $urandom();
         if (r < 5) begin
            queue_word(OP_WRITE, off, cnt, val);
            if ($urandom_range(0, 2) == 0) begin
               off = off + $urandom_range(0, 15) - 8;
               if (off < 0) off = 0;
               if (off > STORE_BITS - 1) off = STORE_BITS - 1;
               cnt = pick_count();
            end
            queue_word(OP_READ, off, cnt, $urandom());
         end else if (r < 9) begin
            queue_word(r[0] ? OP_WRITE : OP_READ, off, cnt, val);
         end else begin
            queue_word(($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE,
                       $urandom_range(0, STORE_BITS - 1),
                       $urandom_range(0, 63), $urandom());
         end
      end
      total_words = pending_words.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_fields.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_fields.push_back(access_field(offered_word));
            words_in <= words_in + 1;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_words.size() > QUIET_TAIL &&
                         ((words_in / 150) % 3) != 0 &&
                         $urandom_range(0, 99) < (((words_in / 150) % 3) == 1 ? 20 : 45)) begin
               // burst of idle cycles, its length set by req_gap
               req_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else begin
               offered_word     = pending_words.pop_front();
               req_operation   <= offered_word.op;
               req_bit_offset  <= offered_word.offset;
               req_bit_count   <= offered_word.count;
               req_write_value <= offered_word.value;
               req_valid       <= 1'b1;
            end
         end
      end
   end

   // long response hold-off, lets the core fill and back-pressure the request side
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && words_in >= 250 + 500 * holds_done) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      field_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fields.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: read_value %08h range_error %0d",
                           rsp_read_value, rsp_range_error);
            end else begin
               want = expected_fields.pop_front();
               if (rsp_read_value !== want.read_value ||
                   rsp_range_error !== want.range_error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: read_value exp %08h got %08h, range_error exp %0d got %0d",
                              want.read_value, rsp_read_value, want.range_error,
                              rsp_range_error);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (words_in >= total_words - QUIET_TAIL || ((words_in / 200) % 2) == 0) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_stall = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
